// ----- hdl/touch_level_hysteresis_detector_macros.svh -----
// Assertion macros for the touch level hysteresis detector
`ifndef TOUCH_LEVEL_HYSTERESIS_DETECTOR_MACROS_SVH
`define TOUCH_LEVEL_HYSTERESIS_DETECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define THD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define THD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/thd_pkg.sv -----
// Package: constants and types of the touch level hysteresis detector
`default_nettype none

package thd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_W    = 12;
  localparam int ACC_W       = 20;
  localparam int AVG_W       = 12;
  localparam int BAND_W      = 14;
  localparam int CNT_W       = 8;
  localparam int DIV_STEPS   = ACC_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [ACC_W-1:0]    ACC_MAX     = {ACC_W{1'b1}};
  localparam logic [AVG_W-1:0]    AVG_MAX     = {AVG_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  // Configuration register indexes
  localparam logic [2:0] CFG_ROUNDS     = 3'd0;
  localparam logic [2:0] CFG_BAND_LOW   = 3'd1;
  localparam logic [2:0] CFG_BAND_HIGH  = 3'd2;
  localparam logic [2:0] CFG_HYSTERESIS = 3'd3;
  localparam logic [2:0] CFG_REPORT_ALL = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/touch_level_hysteresis_detector.sv -----
// Top level: touch level detector with averaging, serial divider and hysteresis
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in_     | input     | in_valid/in_ready   | in_raw_sample[11:0]
//  out_    | output    | out_valid/out_ready | out_touched, out_average[11:0]
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index[2:0], cfg_wdata[13:0]
//
// A sample that does not close a group is only accumulated. A sample that
// closes a group is accumulated, divided in the bit-serial restoring divider
// (one quotient bit per cycle through a single 10-bit subtractor) and then
// judged against the band. rst_n is synchronous, active low, and clears all
// control state. A result waits in the output register; a new sample is still
// taken meanwhile, and only a later result stalls in the decide step until
// out_ready frees the register. cfg_ready is always high.
`default_nettype none

module touch_level_hysteresis_detector
  import thd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // sample channel
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [SAMPLE_W-1:0] in_raw_sample,
  // result channel
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic                out_touched,
  output      logic [AVG_W-1:0]    out_average,
  // configuration write channel
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [BAND_W-1:0]   cfg_wdata
);

`include "touch_level_hysteresis_detector_macros.svh"

  // Configuration registers
  logic [CNT_W-1:0]         rounds_r;
  logic signed [BAND_W-1:0] band_low_r;
  logic signed [BAND_W-1:0] band_high_r;
  logic [CNT_W-1:0]         hyst_r;
  logic                     report_all_r;

  // Datapath and control state
  state_t            state_r, state_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;       // sum, then quotient during division
  logic [CNT_W-1:0]  round_cnt_r, round_cnt_nxt;
  logic [CNT_W-1:0]  div_rounds_r, div_rounds_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              button_on_r, button_on_nxt;
  logic [CNT_W-1:0]  defer_r, defer_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_touched_r, out_touched_nxt;
  logic [AVG_W-1:0]  out_average_r, out_average_nxt;

  // Helpers
  logic [CNT_W-1:0]  rounds_eff;
  logic [ACC_W:0]    sum_wide;
  logic [ACC_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  round_cnt_inc;
  logic [CNT_W:0]    div_shift;
  logic [CNT_W+1:0]  div_diff;
  logic              div_ge;
  logic signed [ACC_W:0] avg_s, low_s, high_s;
  logic              qualifies;
  logic              out_free;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_touched = out_touched_r;
  assign out_average = out_average_r;

  // Zero rounds behaves as one
  assign rounds_eff    = (rounds_r == '0) ? CNT_W'(1) : rounds_r;
  assign sum_wide      = {1'b0, acc_r} + (ACC_W+1)'(in_raw_sample & SAMPLE_MASK);
  assign sum_sat       = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];
  assign round_cnt_inc = round_cnt_r + CNT_W'(1);

  // Single subtractor: one restoring-division step per cycle
  assign div_shift = {rem_r, acc_r[ACC_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, div_rounds_r};
  assign div_ge    = !div_diff[CNT_W+1];

  // Average is non-negative; bands are sign-extended for a full-width compare
  assign avg_s  = $signed({1'b0, acc_r});
  assign low_s  = (ACC_W+1)'(band_low_r);
  assign high_s = (ACC_W+1)'(band_high_r);

  // Released: outside the band qualifies. Touched: strictly inside qualifies.
  assign qualifies = button_on_r ? ((avg_s > low_s) && (avg_s < high_s))
                                 : ((avg_s < low_s) || (avg_s > high_s));

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r     <= CNT_W'(4);
      band_low_r   <= '0;
      band_high_r  <= BAND_W'(4095);
      hyst_r       <= CNT_W'(3);
      report_all_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROUNDS:     rounds_r     <= cfg_wdata[CNT_W-1:0];
        CFG_BAND_LOW:   band_low_r   <= $signed(cfg_wdata);
        CFG_BAND_HIGH:  band_high_r  <= $signed(cfg_wdata);
        CFG_HYSTERESIS: hyst_r       <= cfg_wdata[CNT_W-1:0];
        CFG_REPORT_ALL: report_all_r <= cfg_wdata[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      round_cnt_r <= '0;
      button_on_r <= 1'b0;
      defer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      round_cnt_r <= round_cnt_nxt;
      button_on_r <= button_on_nxt;
      defer_r     <= defer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    div_rounds_r  <= div_rounds_nxt;
    rem_r         <= rem_nxt;
    step_r        <= step_nxt;
    out_touched_r <= out_touched_nxt;
    out_average_r <= out_average_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    acc_nxt         = acc_r;
    round_cnt_nxt   = round_cnt_r;
    div_rounds_nxt  = div_rounds_r;
    rem_nxt         = rem_r;
    step_nxt        = step_r;
    button_on_nxt   = button_on_r;
    defer_nxt       = defer_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_touched_nxt = out_touched_r;
    out_average_nxt = out_average_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          acc_nxt       = sum_sat;
          round_cnt_nxt = round_cnt_inc;
          // group closes once the count reaches the current setting
          if (round_cnt_inc >= rounds_eff) begin
            div_rounds_nxt = rounds_eff;
            rem_nxt        = '0;
            step_nxt       = '0;
            state_nxt      = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
        acc_nxt  = {acc_r[ACC_W-2:0], div_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (qualifies && (defer_r < hyst_r)) begin
          // deferred average, silent
          defer_nxt     = defer_r + CNT_W'(1);
          acc_nxt       = '0;
          round_cnt_nxt = '0;
          state_nxt     = ST_IDLE;
        end else if (!qualifies && !report_all_r) begin
          acc_nxt       = '0;
          round_cnt_nxt = '0;
          state_nxt     = ST_IDLE;
        end else if (out_free) begin
          // report; flip the state when the average qualified
          if (qualifies) begin
            button_on_nxt = !button_on_r;
            defer_nxt     = '0;
          end
          out_valid_nxt   = 1'b1;
          out_touched_nxt = qualifies ? !button_on_r : button_on_r;
          out_average_nxt = (acc_r > ACC_W'(AVG_MAX)) ? AVG_MAX : acc_r[AVG_W-1:0];
          acc_nxt         = '0;
          round_cnt_nxt   = '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Partial remainder always stays below the divisor
  `THD_ASSERT_IMP(a_rem_below_div, state_r == ST_DIV, rem_r < div_rounds_r,
                  "divider remainder reached divisor")
  // Step counter never runs past the last quotient bit
  `THD_ASSERT_IMP(a_step_range, state_r == ST_DIV, step_r < STEP_W'(DIV_STEPS),
                  "divider step out of range")
  // Button state moves only in the decide step
  `THD_ASSERT_NXT(a_button_only_decide, state_r != ST_DECIDE, $stable(button_on_r),
                  "button state changed outside decide")
  // A sample that does not close a group leaves the block ready
  `THD_ASSERT_NXT(a_open_group_stays_idle,
                  in_valid && in_ready && (round_cnt_inc < rounds_eff),
                  state_r == ST_IDLE, "open group left idle")

endmodule

`default_nettype wire

// ----- test/tb_touch_level_hysteresis_detector.sv -----
// Self-checking testbench for the touch level hysteresis detector
`timescale 1ns / 1ps

module tb_touch_level_hysteresis_detector;
  import thd_pkg::*;

  localparam int  CLK_PERIOD_NS   = 4;
  localparam int  RESET_CYCLES    = 4;
  // a closing sample must still pass the divider and the decide step; leave a margin on top
  localparam int  SETTLE_CYCLES   = 40;
  localparam int  HOLD_OFF_CYCLES = 300;
  localparam int  END_WAIT_CYCLES = 20000;
  localparam int  TIMEOUT_NS      = 4_000_000;
  localparam int  SAMPLE_TOP      = (1 << SAMPLE_W) - 1;

  // which part of the band a run of samples is aimed at
  typedef enum int {
    LVL_INSIDE,
    LVL_ABOVE,
    LVL_BELOW
  } level_zone_t;

  typedef struct {
    logic             touched;
    logic [AVG_W-1:0] average;
  } touch_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_raw_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_touched;
  logic [AVG_W-1:0]    out_average;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [BAND_W-1:0]   cfg_wdata = '0;

  touch_level_hysteresis_detector DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_sample (in_raw_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_touched   (out_touched),
    .out_average   (out_average),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Samples waiting for the driver, and reports the block still owes us
  logic [SAMPLE_W-1:0] sample_queue[$];
  touch_report_t       exp_results[$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  bit hold_off_go    = 1'b0;
  logic rx_hold      = 1'b0;

  // Predictor copy of the registers (reset values)
  logic [CNT_W-1:0] avg_rounds   = 8'd4;
  int               band_lo      = 0;
  int               band_hi      = 4095;
  logic [CNT_W-1:0] hyst_limit   = 8'd3;
  logic             report_every = 1'b0;

  // Predictor copy of the block state
  logic [ACC_W-1:0] acc_sum   = '0;
  logic [CNT_W-1:0] round_cnt = '0;
  logic             btn_on    = 1'b0;
  logic [CNT_W-1:0] defer_cnt = '0;

  initial begin : clock_gen
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_touch_level_hysteresis_detector: FAIL");
    $finish;
  end

  task automatic note_mismatch(input string what, input int want_v, input int got_v);
    $display("[%0t] mismatch: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    mismatch_count++;
  endtask

  // Mirror of a register write as the block should see it
  task automatic apply_reg(input logic [2:0] idx, input logic [BAND_W-1:0] data);
    case (idx)
      CFG_ROUNDS:     avg_rounds = data[CNT_W-1:0];
      CFG_BAND_LOW:   band_lo = $signed(data);
      CFG_BAND_HIGH:  band_hi = $signed(data);
      CFG_HYSTERESIS: hyst_limit = data[CNT_W-1:0];
      CFG_REPORT_ALL: report_every = data[0];
      default: ;
    endcase
  endtask

  // Accumulate one sample; on a closed group, average, judge against the
  // band with hysteresis and queue the report, if any
  task automatic judge_sample(input logic [SAMPLE_W-1:0] raw);
    logic [ACC_W:0] sum;
    int unsigned    rounds;
    int unsigned    avg;
    int             level;
    bit             qualifies;
    bit             changed;
    touch_report_t  rep;
    changed = 1'b0;
    sum = {1'b0, acc_sum} + (ACC_W+1)'(raw & SAMPLE_MASK);
    acc_sum = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
    round_cnt = round_cnt + 8'd1;
    // zero rounds behaves as one
    rounds = (avg_rounds == 0) ? 32'd1 : 32'(avg_rounds);
    if (round_cnt < rounds) return;
    avg = 32'(acc_sum) / rounds;
    acc_sum = '0;
    round_cnt = '0;
    // full-width average takes part in the comparison
    level = int'(avg);
    if (btn_on) qualifies = (level > band_lo) && (level < band_hi);
    else qualifies = (level < band_lo) || (level > band_hi);
    if (qualifies) begin
      if (defer_cnt < hyst_limit) begin
        defer_cnt = defer_cnt + 8'd1;
        return;
      end
      btn_on = ~btn_on;
      defer_cnt = '0;
      changed = 1'b1;
    end
    if (!changed && !report_every) return;
    rep.touched = btn_on;
    rep.average = (avg > AVG_MAX) ? AVG_MAX : AVG_W'(avg);
    exp_results.push_back(rep);
  endtask

  // Driver: one sample transaction at a time from sample_queue. Valid is held
  // with a stable payload until the block takes it; the prediction is made at
  // the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) judge_sample(in_raw_sample);
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          in_raw_sample <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transaction is checked against the oldest report owed
  always @(posedge clk) begin : result_check
    touch_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_results.size() == 0) begin
        note_mismatch("result with none owed, average", -1, out_average);
      end else begin
        want = exp_results.pop_front();
        if (out_touched !== want.touched) note_mismatch("touched", want.touched, out_touched);
        if (out_average !== want.average) note_mismatch("average", want.average, out_average);
      end
    end
    out_ready <= rst_n && !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off, counted here, so the block backs up and stalls
  // its sample input while the driver keeps offering
  initial begin : rx_hold_off
    wait (hold_off_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [BAND_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Sender pause: nothing queued, nothing offered, nothing owed, then let any
  // group still in the divider finish before touching the registers
  task automatic wait_idle();
    @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || exp_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_level(input int lo, input int hi);
    if (lo < 0) lo = 0;
    if (hi > SAMPLE_TOP) hi = SAMPLE_TOP;
    if (lo > hi) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(hi, lo));
  endfunction

  // Runs of samples aimed inside, above or below the band, whole groups long,
  // so averages keep qualifying and the hysteresis gets exercised; some noise
  task automatic queue_samples(input int n);
    int            made;
    int            run;
    int            k;
    level_zone_t   zone;
    logic [SAMPLE_W-1:0] s;
    made = 0;
    while (made < n) begin
      zone = level_zone_t'($urandom_range(2));
      run = ((avg_rounds == 0) ? 1 : avg_rounds) * $urandom_range(10, 1);
      for (k = 0; k < run && made < n; k++) begin
        if ($urandom_range(99) < 85) begin
          case (zone)
            LVL_INSIDE: s = pick_level(band_lo + 1, band_hi - 1);
            LVL_ABOVE:  s = pick_level(band_hi + 1, SAMPLE_TOP);
            default:    s = pick_level(0, band_lo - 1);
          endcase
        end else begin
          s = SAMPLE_W'($urandom);
        end
        sample_queue.push_back(s);
        made++;
      end
    end
  endtask

  // Reprogram every register once the block is quiet, then queue a batch.
  // Spare bits above the 8-bit fields carry random junk that must be ignored.
  task automatic run_phase(input int rounds, input int lo, input int hi, input int hyst,
                           input bit rep, input int n);
    wait_idle();
    write_reg(CFG_ROUNDS, {6'($urandom), 8'(rounds)});
    write_reg(CFG_BAND_LOW, BAND_W'(lo));
    write_reg(CFG_BAND_HIGH, BAND_W'(hi));
    write_reg(CFG_HYSTERESIS, {6'($urandom), 8'(hyst)});
    write_reg(CFG_REPORT_ALL, {13'($urandom), rep});
    @(negedge clk);
    queue_samples(n);
  endtask

  initial begin : main_seq
    int lo;
    int hi;
    int wait_cnt;
    logic [SAMPLE_W-1:0] q;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly idle
    @(negedge clk);
    send_idle_pct = 11;
    recv_idle_pct = 82;

    // ---- directed part ----
    // Zero rounds (every sample is a group), no hysteresis, report all;
    // extremes of the sample and both band edges exactly
    write_reg(CFG_ROUNDS, '0);
    write_reg(CFG_BAND_LOW, 14'sd100);
    write_reg(CFG_BAND_HIGH, 14'sd3000);
    write_reg(CFG_HYSTERESIS, '0);
    write_reg(CFG_REPORT_ALL, 14'd1);
    // unused indexes must leave the registers alone
    for (int i = CFG_REPORT_ALL + 1; i < 8; i++) write_reg(3'(i), BAND_W'($urandom));
    @(negedge clk);
    sample_queue.push_back(12'd0);
    sample_queue.push_back(12'd4095);
    sample_queue.push_back(12'd2000);
    sample_queue.push_back(12'd50);
    sample_queue.push_back(12'd3000);
    sample_queue.push_back(12'd100);
    sample_queue.push_back(12'd2999);
    sample_queue.push_back(12'd101);
    sample_queue.push_back(12'd3001);

    // Rounds lowered mid-group: five full-scale samples of a six-sample group,
    // then rounds of one closes it with a sum far above the 12-bit range
    // (wide average, compared in full, reported saturated); band at its extremes
    wait_idle();
    write_reg(CFG_ROUNDS, 14'd6);
    @(negedge clk);
    repeat (5) sample_queue.push_back(12'd4095);
    wait_idle();
    write_reg(CFG_ROUNDS, 14'd1);
    write_reg(CFG_BAND_LOW, BAND_W'(-8192));
    write_reg(CFG_BAND_HIGH, 14'sd8191);
    @(negedge clk);
    sample_queue.push_back(12'd4095);

    // Hysteresis lowered below the count already reached
    wait_idle();
    write_reg(CFG_BAND_LOW, 14'sd1000);
    write_reg(CFG_BAND_HIGH, 14'sd2000);
    write_reg(CFG_HYSTERESIS, 14'd5);
    write_reg(CFG_REPORT_ALL, 14'd0);
    @(negedge clk);
    q = btn_on ? 12'd1500 : 12'd4000;
    repeat (4) sample_queue.push_back(q);
    wait_idle();
    write_reg(CFG_HYSTERESIS, 14'd2);
    @(negedge clk);
    q = btn_on ? 12'd1500 : 12'd4000;
    sample_queue.push_back(q);

    // ---- random part ----
    // at most one report per sample, then hold the receiver off for a long stretch
    run_phase(1, 1000, 3000, 1, 1'b1, 150);
    hold_off_go = 1'b1;
    run_phase(3, $urandom_range(2000), 2000 + $urandom_range(2000), 2, 1'b0, 150);
    // largest groups, only one of them closes
    run_phase(255, 500, 3500, 0, 1'b1, 260);
    // deepest hysteresis
    run_phase(1, 1500, 2500, 255, 1'b1, 300);

    for (int ph = 4; ph < 12; ph++) begin
      if (ph == 4) begin
        // sender mostly idle, receiver mostly ready
        wait_idle();
        send_idle_pct = 82;
        recv_idle_pct = 11;
      end
      if (ph == 8) begin
        // flat out on both sides
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      lo = $urandom_range(3000);
      hi = lo + $urandom_range(1500, 1);
      case (ph)
        5: begin
          lo = -8192;
          hi = 8191;
        end
        7: begin
          // crossed band
          lo = 3000;
          hi = 1000;
        end
        9: begin
          lo = int'($urandom_range(16383)) - 8192;
          hi = int'($urandom_range(16383)) - 8192;
        end
        default: ;
      endcase
      run_phase((ph == 6) ? 0 : $urandom_range(8, 1), lo, hi, $urandom_range(6),
                (ph == 5) ? 1'b1 : 1'($urandom), 100);
    end

    // ---- wind down ----
    @(negedge clk);
    while (sample_queue.size() != 0 || in_valid) @(negedge clk);
    for (wait_cnt = 0; wait_cnt < END_WAIT_CYCLES && exp_results.size() != 0; wait_cnt++)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (exp_results.size() != 0) note_mismatch("reports never delivered", 0, exp_results.size());

    if (mismatch_count == 0) begin
      $display("tb_touch_level_hysteresis_detector: PASS");
    end else begin
      $display("tb_touch_level_hysteresis_detector: FAIL");
    end
    $finish;
  end

endmodule

// ----- touch_level_hysteresis_detector.f -----
+incdir+hdl
hdl/thd_pkg.sv
hdl/touch_level_hysteresis_detector.sv
test/tb_touch_level_hysteresis_detector.sv
